@@ hdl/script_source_tokenizer_defines.svh @@
// assertion macros for the script source tokenizer checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef SCRIPT_SOURCE_TOKENIZER_DEFINES_SVH
`define SCRIPT_SOURCE_TOKENIZER_DEFINES_SVH

// same-cycle implication, off while in reset
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sst_pkg.sv @@
// shared types, token codes and keyword table for the script source tokenizer
// no dependencies
package sst_pkg;

    localparam int SOURCE_BYTES_DEF = 65536;
    localparam int KEYWORD_MAX_DEF  = 9;

    localparam int MAX_RES     = 3;
    localparam int PUSH_W      = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH  = 4;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] ST_TOKEN      = 2'd0;
    localparam logic [1:0] ST_UNEXPECTED = 2'd1;
    localparam logic [1:0] ST_UNTERM     = 2'd2;

    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_STAR    = 6'd9;
    localparam logic [5:0] K_BANG    = 6'd10;
    localparam logic [5:0] K_EQUAL   = 6'd12;
    localparam logic [5:0] K_LESS    = 6'd14;
    localparam logic [5:0] K_GREATER = 6'd16;
    localparam logic [5:0] K_SLASH   = 6'd18;
    localparam logic [5:0] K_STRING  = 6'd19;
    localparam logic [5:0] K_NUMBER  = 6'd20;
    localparam logic [5:0] K_IDENT   = 6'd21;
    localparam logic [5:0] K_KW0     = 6'd22;
    localparam logic [5:0] K_EOF     = 6'd37;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int KW_COUNT = 15;
    localparam int KW_CHARS = 9;

    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "and", "else", "false", "for", "function", "if", "null", "undefined",
        "or", "print", "return", "this", "true", "var", "while"
    };
    localparam int KW_LEN [KW_COUNT] = '{3, 4, 5, 3, 8, 2, 4, 9, 2, 5, 6, 4, 4, 3, 5};

    typedef struct packed {
        logic       cmd;
        logic [7:0] source_byte;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  status;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_result;
    } t_out_beat;

    typedef struct packed {
        logic [PUSH_W-1:0]             count;
        t_out_beat [MAX_RES-1:0]       rec;
    } t_push;

    function automatic logic [7:0] kw_byte(int i, int j);
        logic [8*KW_CHARS-1:0] w;
        w = KW_TEXT[i] >> (8 * (KW_LEN[i] - 1 - j));
        return w[7:0];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            "<":     k = K_LESS;
            default: k = K_GREATER;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] span(logic [15:0] from, logic [15:0] to);
        return (to >= from) ? to - from : 16'd0;
    endfunction

    function automatic logic [15:0] bump_sat(logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic t_out_beat mk(logic [5:0] kind, logic [1:0] st,
                                     logic [15:0] start, logic [15:0] len);
        t_out_beat r;
        r.token_kind   = kind;
        r.status       = st;
        r.token_start  = start;
        r.token_length = len;
        r.line_number  = 16'd0;
        r.last_result  = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/script_source_tokenizer.sv @@
// channel | direction | handshake                  | payload
// source  | in        | i_src_valid / o_src_ready  | i_src_data (cmd, source_byte)
// token   | out       | o_tok_valid / i_tok_ready  | o_tok_data (kind, status, span, line)
//
// top level of the script source tokenizer; depends on sst_pkg, sst_scan, sst_fifo
// one source beat per cycle while source ready is high; the scanner decides each
// beat combinationally and writes zero to three records into a four-entry result queue
// the queue sends one token beat per cycle while token ready is high, one per record
// source ready drops while fewer than three queue entries are free
// reset is synchronous, the keyword buffer is not cleared
module script_source_tokenizer #(
    parameter int SOURCE_BYTES = sst_pkg::SOURCE_BYTES_DEF,
    parameter int KEYWORD_MAX  = sst_pkg::KEYWORD_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_src_valid,
    output logic               o_src_ready,
    input  sst_pkg::t_in_beat  i_src_data,
    output logic               o_tok_valid,
    input  logic               i_tok_ready,
    output sst_pkg::t_out_beat o_tok_data
);
    import sst_pkg::*;

    t_push push;
    logic  src_accept;

    assign src_accept = i_src_valid && o_src_ready;

    sst_scan #(
        .SOURCE_BYTES (SOURCE_BYTES),
        .KEYWORD_MAX  (KEYWORD_MAX)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (src_accept),
        .i_data   (i_src_data),
        .o_push   (push)
    );

    sst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_src_ready),
        .o_valid (o_tok_valid),
        .i_ready (i_tok_ready),
        .o_data  (o_tok_data)
    );

endmodule

@@ hdl/sst_scan.sv @@
// scanner state and per-byte token logic, up to three records per beat
// depends on sst_pkg
module sst_scan #(
    parameter int SOURCE_BYTES = sst_pkg::SOURCE_BYTES_DEF,
    parameter int KEYWORD_MAX  = sst_pkg::KEYWORD_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  sst_pkg::t_in_beat i_data,
    output sst_pkg::t_push   o_push
);
    import sst_pkg::*;

    localparam int          IDX_W      = $clog2(KEYWORD_MAX);
    localparam logic [15:0] OFFSET_MAX = (SOURCE_BYTES < 65535) ? 16'(SOURCE_BYTES) : 16'hFFFF;
    localparam logic [15:0] WORD_KEEP  = 16'(KEYWORD_MAX);

    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_OP      = 9'b000000010,
        M_SLASH   = 9'b000000100,
        M_COMMENT = 9'b000001000,
        M_STRING  = 9'b000010000,
        M_INT     = 9'b000100000,
        M_DOT     = 9'b001000000,
        M_FRAC    = 9'b010000000,
        M_WORD    = 9'b100000000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_tb, n_tb;
    logic [15:0] r_off, n_off;
    logic [15:0] r_line, n_line;
    logic [7:0]  r_pend, n_pend;
    logic [15:0] r_wlen, n_wlen;
    logic [7:0]  r_word [KEYWORD_MAX];

    logic             w_en;
    logic [IDX_W-1:0] w_idx;
    logic [7:0]       c;
    logic [15:0]      off_inc, off_m1;
    logic [5:0]       word_kind;
    logic             f0_v, f1_v, t_v, go_idle;
    t_out_beat        f0, f1, tl;
    t_out_beat [MAX_RES-1:0] recs;
    logic [PUSH_W-1:0] cnt;

    assign c       = i_data.source_byte;
    assign off_inc = (r_off < OFFSET_MAX) ? r_off + 16'd1 : OFFSET_MAX;
    assign off_m1  = r_off - 16'd1;

    always_comb begin : p_kw
        logic hit;
        word_kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (r_wlen == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_CHARS; j++) begin
                if (j < KW_LEN[i] && r_word[j] != kw_byte(i, j)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                word_kind = K_KW0 + 6'(i);
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_tb    = r_tb;
        n_off   = r_off;
        n_line  = r_line;
        n_pend  = r_pend;
        n_wlen  = r_wlen;
        w_en    = 1'b0;
        w_idx   = r_wlen[IDX_W-1:0];
        f0_v    = 1'b0;
        f1_v    = 1'b0;
        t_v     = 1'b0;
        go_idle = 1'b0;
        f0      = mk(K_NUMBER, ST_TOKEN, r_tb, span(r_tb, r_off));
        f1      = mk(K_DOT, ST_TOKEN, off_m1, 16'd1);
        tl      = mk(K_EOF, ST_TOKEN, r_off, 16'd0);

        if (i_data.cmd == CMD_END) begin
            unique case (r_mode)
                M_OP: begin
                    f0_v = 1'b1;
                    f0   = mk(op_kind(r_pend), ST_TOKEN, r_tb, span(r_tb, r_off));
                end
                M_SLASH: begin
                    f0_v = 1'b1;
                    f0   = mk(K_SLASH, ST_TOKEN, r_tb, span(r_tb, r_off));
                end
                M_STRING: begin
                    f0_v = 1'b1;
                    f0   = mk(6'd0, ST_UNTERM, r_tb, span(r_tb, r_off));
                end
                M_INT, M_FRAC: begin
                    f0_v = 1'b1;
                end
                M_DOT: begin
                    f0_v = 1'b1;
                    f0   = mk(K_NUMBER, ST_TOKEN, r_tb, span(r_tb, off_m1));
                    f1_v = 1'b1;
                end
                M_WORD: begin
                    f0_v = 1'b1;
                    f0   = mk(word_kind, ST_TOKEN, r_tb, span(r_tb, r_off));
                end
                default: ;
            endcase
            t_v    = 1'b1;
            n_mode = M_IDLE;
            n_tb   = 16'd0;
            n_off  = 16'd0;
            n_line = 16'd1;
            n_wlen = 16'd0;
        end else begin
            unique case (r_mode)
                M_OP: begin
                    f0_v = 1'b1;
                    if (c == "=") begin
                        f0     = mk(op_kind(r_pend) + 6'd1, ST_TOKEN, r_tb,
                                    span(r_tb, off_inc));
                        n_mode = M_IDLE;
                    end else begin
                        f0      = mk(op_kind(r_pend), ST_TOKEN, r_tb, span(r_tb, r_off));
                        go_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        f0_v    = 1'b1;
                        f0      = mk(K_SLASH, ST_TOKEN, r_tb, span(r_tb, r_off));
                        go_idle = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        n_line = bump_sat(r_line);
                        n_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        f0_v   = 1'b1;
                        f0     = mk(K_STRING, ST_TOKEN, r_tb, span(r_tb, off_inc));
                        n_mode = M_IDLE;
                    end else if (c == CH_NL) begin
                        n_line = bump_sat(r_line);
                    end
                end
                M_INT: begin
                    if (c == ".") begin
                        n_mode = M_DOT;
                    end else if (!is_digit(c)) begin
                        f0_v    = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        n_mode = M_FRAC;
                    end else begin
                        f0_v    = 1'b1;
                        f0      = mk(K_NUMBER, ST_TOKEN, r_tb, span(r_tb, off_m1));
                        f1_v    = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit(c)) begin
                        f0_v    = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_letter(c)) begin
                        w_en   = (r_wlen < WORD_KEEP);
                        n_wlen = bump_sat(r_wlen);
                    end else begin
                        f0_v    = 1'b1;
                        f0      = mk(word_kind, ST_TOKEN, r_tb, span(r_tb, r_off));
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    go_idle = 1'b1;
                end
            endcase

            if (go_idle) begin
                n_mode = M_IDLE;
                n_tb   = r_off;
                tl     = mk(6'd0, ST_TOKEN, r_off, 16'd1);
                unique case (c)
                    "(": begin t_v = 1'b1; tl.token_kind = K_LPAREN; end
                    ")": begin t_v = 1'b1; tl.token_kind = K_RPAREN; end
                    "{": begin t_v = 1'b1; tl.token_kind = K_LBRACE; end
                    "}": begin t_v = 1'b1; tl.token_kind = K_RBRACE; end
                    ",": begin t_v = 1'b1; tl.token_kind = K_COMMA; end
                    ".": begin t_v = 1'b1; tl.token_kind = K_DOT; end
                    "-": begin t_v = 1'b1; tl.token_kind = K_MINUS; end
                    "+": begin t_v = 1'b1; tl.token_kind = K_PLUS; end
                    ";": begin t_v = 1'b1; tl.token_kind = K_SEMI; end
                    "*": begin t_v = 1'b1; tl.token_kind = K_STAR; end
                    "!", "=", "<", ">": begin
                        n_pend = c;
                        n_mode = M_OP;
                    end
                    "/":               n_mode = M_SLASH;
                    " ", CH_CR, CH_TAB: ;
                    CH_NL:             n_line = bump_sat(r_line);
                    CH_QUOTE:          n_mode = M_STRING;
                    default: begin
                        if (is_digit(c)) begin
                            n_mode = M_INT;
                        end else if (is_letter(c)) begin
                            w_en   = 1'b1;
                            w_idx  = '0;
                            n_wlen = 16'd1;
                            n_mode = M_WORD;
                        end else begin
                            t_v       = 1'b1;
                            tl.status = ST_UNEXPECTED;
                        end
                    end
                endcase
            end
            n_off = off_inc;
        end
    end

    always_comb begin
        recs[0] = f0_v ? f0 : tl;
        recs[1] = f1_v ? f1 : tl;
        recs[2] = tl;
        cnt     = PUSH_W'(f0_v) + PUSH_W'(f1_v) + PUSH_W'(t_v);
        for (int k = 0; k < MAX_RES; k++) begin
            recs[k].line_number = r_line;
            recs[k].last_result = (PUSH_W'(k) == cnt - PUSH_W'(1));
        end
        o_push.rec   = recs;
        o_push.count = i_accept ? cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_tb   <= 16'd0;
            r_off  <= 16'd0;
            r_line <= 16'd1;
            r_pend <= 8'd0;
            r_wlen <= 16'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_tb   <= n_tb;
            r_off  <= n_off;
            r_line <= n_line;
            r_pend <= n_pend;
            r_wlen <= n_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_data.cmd == CMD_BYTE && w_en) begin
            r_word[w_idx] <= c;
        end
    end

endmodule

@@ hdl/sst_fifo.sv @@
// result queue: takes up to three records a cycle, gives one beat a cycle while ready is high
// depends on sst_pkg
module sst_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sst_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output sst_pkg::t_out_beat o_data
);
    import sst_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_out_beat        r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_cnt <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(i_push.count);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(i_push.count)) begin
                r_mem[r_wr + PTR_W'(k)] <= i_push.rec[k];
            end
        end
    end

endmodule

@@ hdl/sst_checker.sv @@
// port-level checks on the token channel of the script source tokenizer
// depends on sst_pkg and script_source_tokenizer_defines.svh; bound to the top level
`include "script_source_tokenizer_defines.svh"

module sst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_tok_valid,
    input logic               i_tok_ready,
    input sst_pkg::t_out_beat o_tok_data
);
    import sst_pkg::*;

    `SST_ASSERT_NEXT(a_valid_held, o_tok_valid && !i_tok_ready, o_tok_valid, "token beat dropped while stalled")
    `SST_ASSERT_NEXT(a_data_held, o_tok_valid && !i_tok_ready, $stable(o_tok_data), "token beat changed while stalled")
    `SST_ASSERT_NOW(a_eof_shape, o_tok_valid && o_tok_data.token_kind == K_EOF, o_tok_data.last_result && o_tok_data.token_length == 16'd0 && o_tok_data.status == ST_TOKEN, "bad end-of-file record")
    `SST_ASSERT_NOW(a_error_kind, o_tok_valid && o_tok_data.status != ST_TOKEN, o_tok_data.token_kind == 6'd0 && (o_tok_data.status == ST_UNEXPECTED || o_tok_data.status == ST_UNTERM), "bad error record")

endmodule

bind script_source_tokenizer sst_checker u_sst_checker (.*);
